/* design/array_list_sort_search_engine_macros.svh */
// Assertion macros for the array list engine.
// Depends on nothing; included by the top level.
`ifndef ARRAY_LIST_SORT_SEARCH_ENGINE_MACROS_SVH
`define ARRAY_LIST_SORT_SEARCH_ENGINE_MACROS_SVH
// check an implication on every clock edge outside reset
`define ALS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// check an implication in the cycle after the antecedent
`define ALS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/als_pkg.sv */
// Shared constants and types for the array list engine.
// Depends on nothing.
package als_pkg;
  localparam int Depth   = 64;
  localparam int Width   = 32;
  localparam int AddrW   = $clog2(Depth);
  localparam int CntW    = $clog2(Depth + 1);

  typedef enum logic [3:0] {
    ACT_CLEAR  = 4'd0,
    ACT_APPEND = 4'd1,
    ACT_INSERT = 4'd2,
    ACT_EDIT   = 4'd3,
    ACT_DELETE = 4'd4,
    ACT_SORTUP = 4'd5,
    ACT_SORTDN = 4'd6,
    ACT_LFIND  = 4'd7,
    ACT_BFIND  = 4'd8,
    ACT_DUMP   = 4'd9
  } action_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;
endpackage

/* design/als_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module als_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* design/array_list_sort_search_engine.sv */
// Array list engine: one beat per command, results on a one-cycle strobe.
// Insert, delete and linear find step through the list entry by entry; binary find halves
// its range per probe; dump gives one result beat per entry (a single beat if empty).
// Sort compares position i with every later position j and swaps when out of order.
// One command at a time: busy drops as the last result beat is driven; no receiver stall.
// Reset clears the count and control; stored entries stay undefined.
`include "array_list_sort_search_engine_macros.svh"
module array_list_sort_search_engine
  import als_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [3:0]              action_i,
  input  logic [6:0]              position_i,
  input  logic signed [Width-1:0] item_value_i,
  output logic                    strobe,
  output logic [1:0]              status_o,
  output logic [6:0]              found_at_o,
  output logic signed [Width-1:0] entry_value_o,
  output logic [6:0]              entry_count_o,
  output logic                    last_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_USE, S_SORT_B, S_SORT_W, S_BMID, S_DONE
  } state_e;

  state_e             state_q;
  action_e            act_q;
  logic [Width-1:0]   val_q, a_q;
  logic [CntW-1:0]    cnt_q, i_q, j_q, lo_q, hi_q;
  logic               sw_q;
  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic [Width-1:0]   wdata, rdata;
  logic [CntW:0]      mid_sum;
  logic [CntW-1:0]    mid;

  als_ram #(.W(Width), .D(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign busy = (state_q != S_IDLE);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = mid_sum[CntW:1];

  function automatic logic gt(logic [Width-1:0] x, logic [Width-1:0] y);
    return $signed(x) > $signed(y);
  endfunction

  // read address: i_q for scans (i_q-1 for insert); j_q for sort compare partner; mid-1 for binary find
  always_comb begin
    raddr = i_q[AddrW-1:0];
    if (state_q == S_RD && act_q == ACT_INSERT) raddr = AddrW'(i_q - 1'b1);
    if (state_q == S_SORT_B) raddr = j_q[AddrW-1:0];
    if (state_q == S_BMID)   raddr = AddrW'(mid - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0; strobe <= 1'b0; last_o <= 1'b0;
      i_q <= '0; j_q <= '0; lo_q <= '0; hi_q <= '0; sw_q <= 1'b0;
      act_q <= ACT_CLEAR; val_q <= '0; a_q <= '0;
      status_o <= ST_OK; found_at_o <= '0; entry_value_o <= '0; entry_count_o <= '0;
      we <= 1'b0; waddr <= '0; wdata <= '0;
    end else begin
      strobe <= 1'b0;
      we <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) begin
          act_q <= action_e'(action_i);
          val_q <= item_value_i;
          status_o <= ST_OK; found_at_o <= '0; entry_value_o <= '0; last_o <= 1'b1;
          state_q <= S_DONE;
          unique case (action_i)
            ACT_CLEAR: cnt_q <= '0;
            ACT_APPEND:
              if (cnt_q >= CntW'(Depth)) status_o <= ST_FULL;
              else begin
                we <= 1'b1; waddr <= cnt_q[AddrW-1:0]; wdata <= item_value_i;
                cnt_q <= cnt_q + 1'b1;
              end
            ACT_INSERT:
              if (position_i == 7'd0 || {1'b0, position_i} > {1'b0, 7'(cnt_q)} + 8'd1)
                status_o <= ST_BAD_POS;
              else if (cnt_q >= CntW'(Depth)) status_o <= ST_FULL;
              else begin
                // walk down from count: copy i-1 to i
                j_q <= CntW'(position_i) - 1'b1;
                i_q <= cnt_q;
                state_q <= S_RD;
              end
            ACT_EDIT:
              if (position_i == 7'd0 || CntW'(position_i) > cnt_q) status_o <= ST_BAD_POS;
              else begin
                we <= 1'b1; waddr <= AddrW'(position_i - 7'd1); wdata <= item_value_i;
              end
            ACT_DELETE:
              if (position_i == 7'd0 || CntW'(position_i) > cnt_q) status_o <= ST_BAD_POS;
              else begin
                i_q <= CntW'(position_i);
                state_q <= S_RD;
              end
            ACT_SORTUP, ACT_SORTDN: begin
              i_q <= '0; j_q <= CntW'(1);
              if (cnt_q > CntW'(1)) state_q <= S_WAIT;
            end
            ACT_LFIND: begin
              i_q <= '0;
              status_o <= ST_NOTFOUND;
              if (cnt_q != '0) state_q <= S_RD;
            end
            ACT_BFIND: begin
              lo_q <= CntW'(1); hi_q <= cnt_q;
              status_o <= ST_NOTFOUND;
              if (cnt_q != '0) state_q <= S_BMID;
            end
            ACT_DUMP: begin
              i_q <= '0;
              if (cnt_q != '0) state_q <= S_RD;
            end
            default: ;
          endcase
        end
        S_RD: begin
          // address i_q presented; for insert read i-1
          if (act_q == ACT_INSERT) begin
            if (i_q == j_q) begin
              we <= 1'b1; waddr <= j_q[AddrW-1:0]; wdata <= val_q;
              cnt_q <= cnt_q + 1'b1;
              state_q <= S_DONE;
            end else begin
              i_q <= i_q - 1'b1;
              state_q <= S_USE;
            end
          end else if (act_q == ACT_DELETE && i_q >= cnt_q) begin
            cnt_q <= cnt_q - 1'b1;
            state_q <= S_DONE;
          end else state_q <= S_USE;
        end
        S_USE: begin
          unique case (act_q)
            ACT_INSERT: begin
              we <= 1'b1; waddr <= AddrW'(i_q + 1'b1); wdata <= rdata;
              state_q <= S_RD;
            end
            ACT_DELETE: begin
              we <= 1'b1; waddr <= AddrW'(i_q - 1'b1); wdata <= rdata;
              i_q <= i_q + 1'b1;
              state_q <= S_RD;
            end
            ACT_LFIND:
              if (rdata == val_q) begin
                status_o <= ST_OK; found_at_o <= 7'(i_q + 1'b1); state_q <= S_DONE;
              end else if (i_q + 1'b1 >= cnt_q) state_q <= S_DONE;
              else begin
                i_q <= i_q + 1'b1; state_q <= S_RD;
              end
            ACT_BFIND:
              if (rdata == val_q) begin
                status_o <= ST_OK; found_at_o <= 7'(i_q); state_q <= S_DONE;
              end else if (gt(val_q, rdata)) begin
                lo_q <= i_q + 1'b1; state_q <= S_BMID;
              end else if (i_q == CntW'(1)) state_q <= S_DONE;
              else begin
                hi_q <= i_q - 1'b1; state_q <= S_BMID;
              end
            default: begin
              // dump beat
              strobe <= 1'b1; status_o <= ST_OK; found_at_o <= '0;
              entry_value_o <= rdata; entry_count_o <= 7'(cnt_q);
              last_o <= (i_q + 1'b1 == cnt_q);
              if (i_q + 1'b1 == cnt_q) state_q <= S_IDLE;
              else begin
                i_q <= i_q + 1'b1; state_q <= S_RD;
              end
            end
          endcase
        end
        S_WAIT: state_q <= S_SORT_B;   // a (i_q) read in flight
        S_SORT_B: begin
          if (j_q == i_q + 1'b1) a_q <= rdata;   // b (j_q) read in flight
          state_q <= S_SORT_W;
        end
        S_SORT_W: begin
          sw_q <= (act_q == ACT_SORTUP) ? gt(a_q, rdata) : gt(rdata, a_q);
          if ((act_q == ACT_SORTUP) ? gt(a_q, rdata) : gt(rdata, a_q)) begin
            we <= 1'b1; waddr <= i_q[AddrW-1:0]; wdata <= rdata;
            a_q <= rdata;
            val_q <= a_q;
          end
          state_q <= S_BMID;
        end
        S_BMID: begin
          if (act_q == ACT_BFIND) begin
            i_q <= mid;
            state_q <= (lo_q <= hi_q) ? S_USE : S_DONE;
          end else begin
            // finish sort step: write old a to j if swapped
            if (sw_q) begin
              we <= 1'b1; waddr <= j_q[AddrW-1:0]; wdata <= val_q;
            end
            if (j_q + 1'b1 < cnt_q) begin
              j_q <= j_q + 1'b1; state_q <= S_SORT_B;
            end else if (i_q + 2'd2 < cnt_q) begin
              i_q <= i_q + 1'b1; j_q <= i_q + 2'd2; state_q <= S_WAIT;
            end else state_q <= S_DONE;
          end
        end
        S_DONE: begin
          strobe <= 1'b1; last_o <= 1'b1; entry_count_o <= 7'(cnt_q);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ALS_ASSERT_IMP(a_strobe_busy, clk_i, rst_ni, strobe && !last_o, busy)
  `ALS_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(Depth))
  `ALS_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
endmodule

/* bench/tb.sv */
// Testbench for array_list_sort_search_engine: directed, full-list and random command beats.
// Holds its own list predictor and checks every result strobe; depends on als_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
  import als_pkg::*;

  typedef struct packed {
    logic [1:0]              status;
    logic [6:0]              found_at;
    logic signed [Width-1:0] entry_value;
    logic [6:0]              entry_count;
    logic                    last;
  } list_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [3:0]              action_i = 4'd0;
  logic [6:0]              position_i = 7'd0;
  logic signed [Width-1:0] item_value_i = '0;
  logic                    strobe;
  logic [1:0]              status_o;
  logic [6:0]              found_at_o;
  logic signed [Width-1:0] entry_value_o;
  logic [6:0]              entry_count_o;
  logic                    last_o;

  logic signed [Width-1:0] list_words [Depth];
  int                      list_len = 0;
  list_result_t            pending_results [$];
  bit                      failed = 0;
  bit                      gaps_on = 1;
  int unsigned             cycle_cnt = 0;

  array_list_sort_search_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .position_i(position_i), .item_value_i(item_value_i),
    .strobe(strobe), .status_o(status_o), .found_at_o(found_at_o),
    .entry_value_o(entry_value_o), .entry_count_o(entry_count_o), .last_o(last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void push_result(logic [1:0] st, int fnd, logic signed [Width-1:0] v,
                                      logic lst);
    list_result_t r;
    r.status      = st;
    r.found_at    = fnd[6:0];
    r.entry_value = v;
    r.entry_count = list_len[6:0];
    r.last        = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void sort_list(bit descending);
    logic signed [Width-1:0] t;
    for (int i = 0; i + 1 < list_len; i++)
      for (int j = i + 1; j < list_len; j++)
        if (descending ? (list_words[i] < list_words[j]) : (list_words[i] > list_words[j])) begin
          t = list_words[i];
          list_words[i] = list_words[j];
          list_words[j] = t;
        end
  endfunction

  function automatic void predict_list(logic [3:0] act, int pos, logic signed [Width-1:0] v);
    logic [1:0] st;
    int fnd;
    int lo;
    int hi;
    int mid;
    st  = ST_OK;
    fnd = 0;
    case (action_e'(act))
      ACT_CLEAR: list_len = 0;
      ACT_APPEND: begin
        if (list_len >= Depth) st = ST_FULL;
        else begin
          list_words[list_len] = v;
          list_len++;
        end
      end
      ACT_INSERT: begin
        if (pos < 1 || pos > list_len + 1) st = ST_BAD_POS;
        else if (list_len >= Depth) st = ST_FULL;
        else begin
          for (int i = list_len; i >= pos; i--) list_words[i] = list_words[i-1];
          list_words[pos-1] = v;
          list_len++;
        end
      end
      ACT_EDIT: begin
        if (pos < 1 || pos > list_len) st = ST_BAD_POS;
        else list_words[pos-1] = v;
      end
      ACT_DELETE: begin
        if (pos < 1 || pos > list_len) st = ST_BAD_POS;
        else begin
          for (int i = pos - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ACT_SORTUP: sort_list(0);
      ACT_SORTDN: sort_list(1);
      ACT_LFIND: begin
        st = ST_NOTFOUND;
        for (int i = 0; i < list_len; i++)
          if (list_words[i] == v) begin
            st  = ST_OK;
            fnd = i + 1;
            break;
          end
      end
      ACT_BFIND: begin
        st = ST_NOTFOUND;
        lo = 0;
        hi = list_len - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (list_words[mid] == v) begin
            st  = ST_OK;
            fnd = mid + 1;
            break;
          end
          if (list_words[mid] < v) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      ACT_DUMP: begin
        if (list_len == 0) push_result(ST_OK, 0, '0, 1'b1);
        for (int i = 0; i < list_len; i++)
          push_result(ST_OK, 0, list_words[i], i + 1 == list_len);
        return;
      end
      default: ;
    endcase
    push_result(st, fnd, '0, 1'b1);
  endfunction

  task automatic send_beat(action_e act, int pos, logic signed [Width-1:0] v);
    do @(posedge clk_i); while (busy);
    if (gaps_on && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) @(posedge clk_i);
    action_i     <= act;
    position_i   <= pos[6:0];
    item_value_i <= v;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_list(act, pos, v);
    start <= 1'b0;
  endtask

  function automatic logic signed [Width-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(Width-1){1'b0}}};
      1: return {1'b0, {(Width-1){1'b1}}};
      2: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [Width-1:0] listed_or_random();
    if (list_len > 0 && $urandom_range(0, 2) != 0)
      return list_words[$urandom_range(0, list_len - 1)];
    return pick_value();
  endfunction

  always @(posedge clk_i) begin
    list_result_t e;
    if (rst_ni && strobe) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o);
          failed = 1;
        end
        if (found_at_o !== e.found_at) begin
          $error("found_at exp %0d got %0d", e.found_at, found_at_o);
          failed = 1;
        end
        if (entry_value_o !== e.entry_value) begin
          $error("entry_value exp %0d got %0d", e.entry_value, entry_value_o);
          failed = 1;
        end
        if (entry_count_o !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, entry_count_o);
          failed = 1;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == 6_000_000) begin
      $display("array_list_sort_search_engine: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(ACT_DUMP, 0, 0);
    send_beat(ACT_BFIND, 0, 5);
    send_beat(ACT_LFIND, 0, 5);
    send_beat(ACT_DELETE, 1, 0);
    send_beat(ACT_APPEND, 0, {1'b1, {(Width-1){1'b0}}});
    send_beat(ACT_APPEND, 0, {1'b0, {(Width-1){1'b1}}});
    send_beat(ACT_APPEND, 0, 0);
    send_beat(ACT_APPEND, 0, -1);
    send_beat(ACT_INSERT, 0, 7);
    send_beat(ACT_INSERT, 6, 7);
    send_beat(ACT_INSERT, 1, 11);
    send_beat(ACT_INSERT, 6, -11);
    send_beat(ACT_EDIT, 0, 3);
    send_beat(ACT_EDIT, 7, 3);
    send_beat(ACT_EDIT, 2, 3);
    send_beat(ACT_DELETE, 127, 0);
    send_beat(ACT_DELETE, 1, 0);
    send_beat(ACT_LFIND, 0, -1);
    send_beat(ACT_LFIND, 0, 99);
    send_beat(ACT_BFIND, 0, 0);
    send_beat(ACT_SORTUP, 0, 0);
    send_beat(ACT_BFIND, 0, 0);
    send_beat(ACT_BFIND, 0, 99);
    send_beat(ACT_SORTDN, 0, 0);
    send_beat(ACT_DUMP, 0, 0);
    send_beat(action_e'(4'd15), 0, -1);
    send_beat(ACT_CLEAR, 0, 0);
  endtask

  task automatic test_full_list();
    send_beat(ACT_CLEAR, 0, 0);
    repeat (Depth) send_beat(ACT_APPEND, 0, pick_value());
    send_beat(ACT_APPEND, 0, 1);
    send_beat(ACT_INSERT, 1, 1);
    send_beat(ACT_INSERT, Depth + 1, 1);
    send_beat(ACT_INSERT, Depth + 2, 1);
    send_beat(ACT_SORTDN, 0, 0);
    send_beat(ACT_DUMP, 0, 0);
    send_beat(ACT_SORTUP, 0, 0);
    repeat (4) send_beat(ACT_BFIND, 0, listed_or_random());
    send_beat(ACT_EDIT, Depth, -5);
    send_beat(ACT_DELETE, Depth, 0);
    send_beat(ACT_CLEAR, 0, 0);
  endtask

  task automatic test_random(int beats);
    int pick;
    int pos;
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 99);
      pos  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                         : $urandom_range(0, list_len + 1);
      if (pick < 28) send_beat(ACT_APPEND, pos, pick_value());
      else if (pick < 42) send_beat(ACT_INSERT, pos, pick_value());
      else if (pick < 50) send_beat(ACT_EDIT, pos, pick_value());
      else if (pick < 62) send_beat(ACT_DELETE, pos, pick_value());
      else if (pick < 72) send_beat(ACT_LFIND, pos, listed_or_random());
      else if (pick < 80) begin
        if ($urandom_range(0, 1)) send_beat(ACT_SORTUP, pos, pick_value());
        send_beat(ACT_BFIND, pos, listed_or_random());
      end else if (pick < 84) send_beat(ACT_SORTUP, pos, pick_value());
      else if (pick < 87) send_beat(ACT_SORTDN, pos, pick_value());
      else if (pick < 92) send_beat(ACT_DUMP, pos, pick_value());
      else if (pick < 95) send_beat(ACT_CLEAR, pos, pick_value());
      else send_beat(action_e'(4'($urandom_range(10, 15))), pos, pick_value());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_list();
    test_random(130);
    gaps_on = 0;
    test_random(50);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed)
      $display("array_list_sort_search_engine: match");
    else
      $display("array_list_sort_search_engine: mismatch");
    $finish;
  end
endmodule

/* array_list_sort_search_engine.f */
+incdir+design
design/als_pkg.sv
design/als_ram.sv
design/array_list_sort_search_engine.sv
bench/tb.sv
